/* rtl/array_list_insert_delete_core_defines.svh */
// assertion macros shared by the array list core
`ifndef ARRAY_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every clock edge outside reset
`define ALID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alid assertion failed");

// next-cycle implication
`define ALID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alid assertion failed");

`else

`define ALID_ASSERT_IMP(label, ante, cons)
`define ALID_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* rtl/alid_pkg.sv */
// shared constants, codes and types of the array list core
package alid_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_HEAD  = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_TAIL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    K_INS_HEAD,
    K_INS_TAIL,
    K_INS_AFTER,
    K_DEL_HEAD,
    K_DEL_TAIL,
    K_DEL_VALUE,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [WORD_W-1:0]  value;
    logic signed [WORD_W-1:0]  key;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHK_LAST,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_INS_WR,
    S_DONE
  } state_t;

endpackage

/* rtl/alid_ram.sv */
// generic single-write, single-read ram with registered read data
module alid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/alid_front.sv */
// front end: takes words, decodes the operation, queues commands
module alid_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [alid_pkg::OP_W-1:0]          in_operation,
  input  logic signed [alid_pkg::WORD_W-1:0] in_value,
  input  logic signed [alid_pkg::WORD_W-1:0] in_key,
  output logic                               q_valid,
  output alid_pkg::cmd_t                     q_cmd,
  input  logic                               q_pop
);

  alid_pkg::cmd_t                 q_mem_r [alid_pkg::QDEPTH];
  logic [alid_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [alid_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [alid_pkg::QPTR_W:0]      fill_r;
  alid_pkg::cmd_t                 cmd_in;
  logic                           push;
  logic                           pop;

  always_comb begin
    cmd_in.value = in_value;
    cmd_in.key   = in_key;
    case (in_operation)
      alid_pkg::OP_INS_HEAD:  cmd_in.kind = alid_pkg::K_INS_HEAD;
      alid_pkg::OP_INS_TAIL:  cmd_in.kind = alid_pkg::K_INS_TAIL;
      alid_pkg::OP_INS_AFTER: cmd_in.kind = alid_pkg::K_INS_AFTER;
      alid_pkg::OP_DEL_HEAD:  cmd_in.kind = alid_pkg::K_DEL_HEAD;
      alid_pkg::OP_DEL_TAIL:  cmd_in.kind = alid_pkg::K_DEL_TAIL;
      alid_pkg::OP_DEL_VALUE: cmd_in.kind = alid_pkg::K_DEL_VALUE;
      default:                cmd_in.kind = alid_pkg::K_NOP;
    endcase
  end

  assign in_stall = (fill_r == (alid_pkg::QPTR_W + 1)'(alid_pkg::QDEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + alid_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + alid_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + (alid_pkg::QPTR_W + 1)'(1);
        2'b01:   fill_r <= fill_r - (alid_pkg::QPTR_W + 1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/alid_back.sv */
// back end: runs each command against the entry ram and returns the result word
`include "array_list_insert_delete_core_defines.svh"

module alid_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  alid_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [alid_pkg::ST_W-1:0]         out_status,
  output logic [alid_pkg::CNT_W-1:0]        out_count
);

  alid_pkg::state_t                 state_r, state_nxt;
  alid_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [alid_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [alid_pkg::CNT_W-1:0]       k_r, k_nxt;
  logic [alid_pkg::CNT_W-1:0]       lo_r, lo_nxt;
  logic [alid_pkg::CNT_W-1:0]       scan_r, scan_nxt;
  logic [alid_pkg::CNT_W-1:0]       chk_r, chk_nxt;
  logic                             pend_r, pend_nxt;
  logic [alid_pkg::ST_W-1:0]        st_r, st_nxt;
  logic                             out_valid_r;
  logic [alid_pkg::ST_W-1:0]        out_status_r;
  logic [alid_pkg::CNT_W-1:0]       out_count_r;
  logic                             out_load;

  logic                             ram_we;
  logic [alid_pkg::IDX_W-1:0]       ram_waddr;
  logic [alid_pkg::WORD_W-1:0]      ram_wdata;
  logic                             ram_re;
  logic [alid_pkg::IDX_W-1:0]       ram_raddr;
  logic [alid_pkg::WORD_W-1:0]      ram_rdata;

  logic                             full;
  logic                             empty;
  logic [alid_pkg::WORD_W-1:0]      target;
  logic                             hit;
  logic [alid_pkg::CNT_W-1:0]       kk;
  logic [alid_pkg::CNT_W-1:0]       rd_idx;

  alid_ram #(
    .WIDTH (alid_pkg::WORD_W),
    .DEPTH (alid_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign full   = (cnt_r == alid_pkg::CNT_W'(alid_pkg::CAPACITY));
  assign empty  = (cnt_r == '0);
  assign target = (cmd_r.kind == alid_pkg::K_INS_AFTER) ? cmd_r.key : cmd_r.value;
  assign hit    = pend_r && (ram_rdata == target);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alid_pkg::S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    k_r    <= k_nxt;
    lo_r   <= lo_nxt;
    scan_r <= scan_nxt;
    chk_r  <= chk_nxt;
    st_r   <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    lo_nxt    = lo_r;
    scan_nxt  = scan_r;
    chk_nxt   = chk_r;
    pend_nxt  = pend_r;
    st_nxt    = st_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = k_r[alid_pkg::IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    kk        = k_r;
    rd_idx    = '0;

    case (state_r)
      alid_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = alid_pkg::S_DISPATCH;
        end
      end

      alid_pkg::S_DISPATCH: begin
        pend_nxt = 1'b0;
        case (cmd_r.kind)
          alid_pkg::K_INS_HEAD, alid_pkg::K_INS_TAIL: begin
            if (full) begin
              st_nxt    = alid_pkg::ST_FULL;
              state_nxt = alid_pkg::S_DONE;
            end else begin
              k_nxt     = cnt_r;
              lo_nxt    = (cmd_r.kind == alid_pkg::K_INS_HEAD) ? '0 : cnt_r;
              state_nxt = alid_pkg::S_SHIFT_UP;
            end
          end
          alid_pkg::K_INS_AFTER: begin
            if (empty) begin
              st_nxt    = alid_pkg::ST_EMPTY;
              state_nxt = alid_pkg::S_DONE;
            end else if (full) begin
              st_nxt    = alid_pkg::ST_FULL;
              state_nxt = alid_pkg::S_DONE;
            end else begin
              scan_nxt  = '0;
              state_nxt = alid_pkg::S_SEARCH;
            end
          end
          alid_pkg::K_DEL_HEAD: begin
            if (empty) begin
              st_nxt    = alid_pkg::ST_EMPTY;
              state_nxt = alid_pkg::S_DONE;
            end else begin
              k_nxt     = '0;
              state_nxt = alid_pkg::S_SHIFT_DN;
            end
          end
          alid_pkg::K_DEL_TAIL: begin
            if (empty) begin
              st_nxt = alid_pkg::ST_EMPTY;
            end else begin
              cnt_nxt = cnt_r - alid_pkg::CNT_W'(1);
              st_nxt  = alid_pkg::ST_OK;
            end
            state_nxt = alid_pkg::S_DONE;
          end
          alid_pkg::K_DEL_VALUE: begin
            if (empty) begin
              st_nxt    = alid_pkg::ST_EMPTY;
              state_nxt = alid_pkg::S_DONE;
            end else begin
              // look at the last entry first
              rd_idx    = cnt_r - alid_pkg::CNT_W'(1);
              ram_re    = 1'b1;
              ram_raddr = rd_idx[alid_pkg::IDX_W-1:0];
              state_nxt = alid_pkg::S_CHK_LAST;
            end
          end
          default: begin
            st_nxt    = alid_pkg::ST_OK;
            state_nxt = alid_pkg::S_DONE;
          end
        endcase
      end

      alid_pkg::S_CHK_LAST: begin
        if (ram_rdata == cmd_r.value) begin
          cnt_nxt   = cnt_r - alid_pkg::CNT_W'(1);
          st_nxt    = alid_pkg::ST_OK;
          state_nxt = alid_pkg::S_DONE;
        end else begin
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = alid_pkg::S_SEARCH;
        end
      end

      alid_pkg::S_SEARCH: begin
        // one read issued and one compare done per cycle
        if (hit) begin
          pend_nxt = 1'b0;
          if (cmd_r.kind == alid_pkg::K_INS_AFTER) begin
            lo_nxt    = chk_r + alid_pkg::CNT_W'(1);
            k_nxt     = cnt_r;
            state_nxt = alid_pkg::S_SHIFT_UP;
          end else begin
            k_nxt     = chk_r;
            state_nxt = alid_pkg::S_SHIFT_DN;
          end
        end else if (scan_r < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = scan_r[alid_pkg::IDX_W-1:0];
          chk_nxt   = scan_r;
          scan_nxt  = scan_r + alid_pkg::CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          st_nxt    = alid_pkg::ST_NOTFOUND;
          state_nxt = alid_pkg::S_DONE;
        end
      end

      alid_pkg::S_SHIFT_UP: begin
        // entry k-1 moves to k, walking down to the gap
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = k_r[alid_pkg::IDX_W-1:0];
          ram_wdata = ram_rdata;
          kk        = k_r - alid_pkg::CNT_W'(1);
        end
        k_nxt = kk;
        if (kk > lo_r) begin
          rd_idx    = kk - alid_pkg::CNT_W'(1);
          ram_re    = 1'b1;
          ram_raddr = rd_idx[alid_pkg::IDX_W-1:0];
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = alid_pkg::S_INS_WR;
        end
      end

      alid_pkg::S_SHIFT_DN: begin
        // entry k+1 moves to k, walking up to the end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = k_r[alid_pkg::IDX_W-1:0];
          ram_wdata = ram_rdata;
          kk        = k_r + alid_pkg::CNT_W'(1);
        end
        k_nxt  = kk;
        rd_idx = kk + alid_pkg::CNT_W'(1);
        if (rd_idx < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx[alid_pkg::IDX_W-1:0];
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          cnt_nxt   = cnt_r - alid_pkg::CNT_W'(1);
          st_nxt    = alid_pkg::ST_OK;
          state_nxt = alid_pkg::S_DONE;
        end
      end

      alid_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r[alid_pkg::IDX_W-1:0];
        ram_wdata = cmd_r.value;
        cnt_nxt   = cnt_r + alid_pkg::CNT_W'(1);
        st_nxt    = alid_pkg::ST_OK;
        state_nxt = alid_pkg::S_DONE;
      end

      alid_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = alid_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = alid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= st_r;
      out_count_r  <= cnt_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  `ALID_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= alid_pkg::CNT_W'(alid_pkg::CAPACITY))
  `ALID_ASSERT_IMP(a_ins_room, state_r == alid_pkg::S_INS_WR, !full)
  `ALID_ASSERT_IMP(a_we_state, ram_we,
                   (state_r == alid_pkg::S_SHIFT_UP) || (state_r == alid_pkg::S_SHIFT_DN) ||
                   (state_r == alid_pkg::S_INS_WR))
  `ALID_ASSERT_NXT(a_done_hold, state_r == alid_pkg::S_DONE, $stable(cnt_r))
  `ALID_ASSERT_NXT(a_load_valid, out_load, out_valid_r && (out_count_r == $past(cnt_r)))

endmodule

/* rtl/array_list_insert_delete_core.sv */
// top level of the array-backed ordered list core
//
//  channel   dir  handshake            payload
//  in_       in   in_valid / in_stall  in_operation, in_value, in_key
//  out_      out  out_valid / out_stall out_status, out_count
//
//  one word in gives one word out, in order; the front queue holds two commands
//  items that walk the list do so in the search and the shift; these move one entry per cycle
//  through the ram's separate read and write ports
//  rst_n is synchronous; it empties the list, the queue and the output register
//  a stalled output holds the back end; the front keeps taking words until its queue fills
module array_list_insert_delete_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [alid_pkg::OP_W-1:0]          in_operation,
  input  logic signed [alid_pkg::WORD_W-1:0] in_value,
  input  logic signed [alid_pkg::WORD_W-1:0] in_key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [alid_pkg::ST_W-1:0]          out_status,
  output logic [alid_pkg::CNT_W-1:0]         out_count
);

  logic           q_valid;
  logic           q_pop;
  alid_pkg::cmd_t q_cmd;

  alid_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_key       (in_key),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  alid_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_count  (out_count)
  );

endmodule
